// File: hw/rtl/qpe_pkg.sv
`default_nettype none

package qpe_pkg;

   // Character codes used by the encoder.
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_EQUALS = 8'h3d;
   localparam logic [7:0] PRINT_LOW   = 8'h21;
   localparam logic [7:0] PRINT_HIGH  = 8'h7e;
   localparam logic [7:0] COLUMN_MAX  = 8'hff;

   // Line limit after reset.
   localparam logic [7:0] LIMIT_RESET = 8'd76;

   // Command queue geometry.
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // What the back end emits after an optional soft break.
   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_HEX     = 2'd1,
      KIND_CRLF    = 2'd2
   } kind_type;

   // One output run, as handed from the front end to the back end.
   typedef struct packed {
      logic       soft_break;
      kind_type   kind;
      logic [7:0] data;
   } cmd_type;

   // Upper-case hex digit for one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      if (nibble < 4'd10) begin
         digit = 8'h30 + {4'd0, nibble};
      end else begin
         digit = 8'h37 + {4'd0, nibble};
      end
      return digit;
   endfunction

   // Number of words in a run, soft break included.
   function automatic logic [2:0] run_length(input cmd_type cmd);
      logic [2:0] body;
      unique case (cmd.kind)
         KIND_LITERAL: body = 3'd1;
         KIND_HEX:     body = 3'd3;
         KIND_CRLF:    body = 3'd2;
         default:      body = 3'd1;
      endcase
      return cmd.soft_break ? body + 3'd3 : body;
   endfunction

   // The word at a given position of a run.
   function automatic logic [7:0] run_byte(input cmd_type cmd, input logic [2:0] step);
      logic [2:0] idx;
      logic [7:0] value;
      idx   = step;
      value = cmd.data;
      if (cmd.soft_break && step < 3'd3) begin
         unique case (step[1:0])
            2'd0:    value = CHAR_EQUALS;
            2'd1:    value = CHAR_CR;
            default: value = CHAR_LF;
         endcase
      end else begin
         if (cmd.soft_break) begin
            idx = step - 3'd3;
         end
         unique case (cmd.kind)
            KIND_LITERAL: value = cmd.data;
            KIND_HEX: begin
               if (idx == 3'd0) begin
                  value = CHAR_EQUALS;
               end else if (idx == 3'd1) begin
                  value = hex_digit(cmd.data[7:4]);
               end else begin
                  value = hex_digit(cmd.data[3:0]);
               end
            end
            KIND_CRLF: value = (idx == 3'd0) ? CHAR_CR : CHAR_LF;
            default:   value = cmd.data;
         endcase
      end
      return value;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qpe_front.sv
`default_nettype none

module qpe_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_write_enable,
   input  wire  [7:0]        csr_write_data,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire  [7:0]        req_in_byte,
   input  wire               req_msg_last,
   input  wire               queue_full,
   output logic              push,
   output qpe_pkg::cmd_type  push_cmd
);

   logic [7:0] limit_ff;
   logic [7:0] column_ff, column_in;
   logic       space_ff, space_in;
   logic       cr_pending_ff, cr_pending_in;

   logic       accept;
   logic       emit;
   logic [7:0] c;
   logic [8:0] col_plus1, col_plus3;
   logic [7:0] col_sat1, col_sat3;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_in_byte;
   assign push      = accept && emit;

   // Saturating column sums for one and three new words.
   assign col_plus1 = {1'b0, column_ff} + 9'd1;
   assign col_plus3 = {1'b0, column_ff} + 9'd3;
   assign col_sat1  = col_plus1[8] ? qpe_pkg::COLUMN_MAX : col_plus1[7:0];
   assign col_sat3  = col_plus3[8] ? qpe_pkg::COLUMN_MAX : col_plus3[7:0];

   // Classify the word and work out the run and the next line state.
   always_comb begin
      emit                = 1'b0;
      push_cmd.soft_break = 1'b0;
      push_cmd.kind       = qpe_pkg::KIND_LITERAL;
      push_cmd.data       = c;
      column_in           = column_ff;
      space_in            = space_ff;
      cr_pending_in       = 1'b0;
      if (cr_pending_ff && c == qpe_pkg::CHAR_LF) begin
         emit                = 1'b1;
         push_cmd.soft_break = space_ff;
         push_cmd.kind       = qpe_pkg::KIND_CRLF;
         column_in           = 8'd0;
         space_in            = 1'b0;
      end else if (c == qpe_pkg::CHAR_CR) begin
         cr_pending_in = !req_msg_last;
      end else if (c == qpe_pkg::CHAR_SPACE || c == qpe_pkg::CHAR_TAB) begin
         if (!req_msg_last) begin
            emit      = 1'b1;
            column_in = col_sat1;
            space_in  = 1'b1;
         end
      end else if (c >= qpe_pkg::PRINT_LOW && c <= qpe_pkg::PRINT_HIGH &&
                   c != qpe_pkg::CHAR_EQUALS) begin
         emit                = 1'b1;
         push_cmd.soft_break = column_ff >= limit_ff;
         column_in           = push_cmd.soft_break ? 8'd1 : col_sat1;
         space_in            = 1'b0;
      end else begin
         emit                = 1'b1;
         push_cmd.soft_break = ({1'b0, column_ff} + 9'd2) >= {1'b0, limit_ff};
         push_cmd.kind       = qpe_pkg::KIND_HEX;
         column_in           = push_cmd.soft_break ? 8'd3 : col_sat3;
         space_in            = 1'b0;
      end
      // The end of a message returns the line state to zero.
      if (req_msg_last) begin
         column_in     = 8'd0;
         space_in      = 1'b0;
         cr_pending_in = 1'b0;
      end
   end

   // Line limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= qpe_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Line state, updated for every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= 8'd0;
         space_ff      <= 1'b0;
         cr_pending_ff <= 1'b0;
      end else if (accept) begin
         column_ff     <= column_in;
         space_ff      <= space_in;
         cr_pending_ff <= cr_pending_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/qpe_queue.sv
`default_nettype none

module qpe_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  qpe_pkg::cmd_type  push_cmd,
   output logic              full,
   input  wire               pop,
   output logic              head_valid,
   output qpe_pkg::cmd_type  head_cmd
);

   qpe_pkg::cmd_type                  mem_ff [qpe_pkg::QUEUE_DEPTH];
   logic [qpe_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [qpe_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [qpe_pkg::QUEUE_AW:0]        count_ff, count_in;

   assign full       = count_ff == (qpe_pkg::QUEUE_AW+1)'(qpe_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/qpe_back.sv
`default_nettype none

module qpe_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               head_valid,
   input  qpe_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   logic       load;
   logic       is_last;
   logic [7:0] next_byte;

   // A new word enters the output register when a command waits and the register is empty or drains.
   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign next_byte = qpe_pkg::run_byte(head_cmd, step_ff);
   assign is_last   = step_ff == qpe_pkg::run_length(head_cmd) - 3'd1;
   assign pop       = load && is_last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = is_last ? 3'd0 : step_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= next_byte;
         last_ff <= is_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/quoted_printable_encoder.sv
// Quoted-printable encoder.
// Message bytes arrive on the req_ channel (valid/ready), one word per
// accepted transfer, with req_msg_last on the final byte of a message.
// Encoded characters leave on the rsp_ channel (valid/ready), one word per
// cycle while the receiver is ready; rsp_run_last marks the last word caused
// by one input byte. An input byte yields zero to six output words: CR, and
// a trailing space or tab, yield none.
// The front end classifies each byte in the cycle it is accepted and queues
// at most one command; the back end expands commands into words. The first
// word of a run passes through the command queue and the output register
// before it is presented. Input is taken every cycle while the four-entry
// command queue has room; sustained throughput is one output word per cycle
// while the receiver is ready, set by the back end. A stalled receiver holds
// the output register, then fills the queue, and only then deasserts req_ready.
// csr_write_enable/csr_write_data set the line limit; the user must write it
// only while idle, which the block does not enforce. Reset (synchronous)
// empties the queue, clears the line state and sets the limit to 76.
`default_nettype none

module quoted_printable_encoder (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_write_enable,
   input  wire  [7:0] csr_write_data,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_in_byte,
   input  wire        req_msg_last,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic             push;
   qpe_pkg::cmd_type push_cmd;
   logic             full;
   logic             pop;
   logic             head_valid;
   qpe_pkg::cmd_type head_cmd;

   // Classification and line state.
   qpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_msg_last     (req_msg_last),
      .queue_full       (full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // Command queue between the two halves.
   qpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Run expansion and output register.
   qpe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

// File: bench/qpe_checker.sv
`timescale 1ns / 100ps

module qpe_checker (
   input  wire       clock,
   input  wire       reset,
   input  wire       csr_write_enable,
   input  wire [7:0] csr_write_data,
   input  wire       req_valid,
   input  wire       req_ready,
   input  wire [7:0] req_in_byte,
   input  wire       req_msg_last,
   input  wire       rsp_valid,
   input  wire       rsp_ready,
   input  wire [7:0] rsp_out_byte,
   input  wire       rsp_run_last,
   output int        fail_count,
   output int        words_pending,
   output int        words_checked
);

   localparam logic [127:0] HEX_CHARS = "0123456789ABCDEF";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } enc_word_type;

   // Shadow copy of the encoder's line state and its line limit.
   logic [7:0] limit_copy = qpe_pkg::LIMIT_RESET;
   logic [7:0] column_count = '0;
   logic       space_at_end = 1'b0;
   logic       cr_waiting = 1'b0;

   // Words that one input byte expands into, and the words still owed.
   logic [7:0]   run_words [0:5];
   int           run_count = 0;
   enc_word_type expected_words [$];
   enc_word_type due;
   int           error_total = 0;
   int           checked_total = 0;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      return HEX_CHARS[8 * (15 - int'(nibble)) +: 8];
   endfunction

   // Every emitted word advances the column, which sticks at its maximum.
   task automatic put_word(input logic [7:0] data);
      if (run_count < 6) begin
         run_words[run_count] = data;
         run_count++;
      end
      if (column_count != qpe_pkg::COLUMN_MAX) begin
         column_count++;
      end
   endtask

   task automatic insert_soft_break();
      put_word(qpe_pkg::CHAR_EQUALS);
      put_word(qpe_pkg::CHAR_CR);
      put_word(qpe_pkg::CHAR_LF);
      column_count = '0;
      space_at_end = 1'b0;
   endtask

   // Handling of a byte that is not the LF of a CR LF pair.
   task automatic encode_plain(input logic [7:0] c, input logic last);
      if (c == qpe_pkg::CHAR_CR) begin
         if (!last) begin
            cr_waiting = 1'b1;
         end
      end else if (c == qpe_pkg::CHAR_SPACE || c == qpe_pkg::CHAR_TAB) begin
         // Whitespace skips the length check; at message end it is dropped.
         if (!last) begin
            put_word(c);
            space_at_end = 1'b1;
         end
      end else if (c >= qpe_pkg::PRINT_LOW && c <= qpe_pkg::PRINT_HIGH &&
                   c != qpe_pkg::CHAR_EQUALS) begin
         if (column_count >= limit_copy) begin
            insert_soft_break();
         end
         put_word(c);
         space_at_end = 1'b0;
      end else begin
         // The escape needs three columns, so the check is made two early.
         if (int'(column_count) + 2 >= int'(limit_copy)) begin
            insert_soft_break();
         end
         put_word(qpe_pkg::CHAR_EQUALS);
         put_word(hex_char(c[7:4]));
         put_word(hex_char(c[3:0]));
         space_at_end = 1'b0;
      end
   endtask

   // Expand one accepted byte into its words and queue them.
   task automatic encode_byte(input logic [7:0] c, input logic last);
      enc_word_type w;
      run_count = 0;
      if (cr_waiting) begin
         cr_waiting = 1'b0;
         if (c == qpe_pkg::CHAR_LF) begin
            if (space_at_end) begin
               insert_soft_break();
            end
            put_word(qpe_pkg::CHAR_CR);
            put_word(qpe_pkg::CHAR_LF);
            column_count = '0;
            space_at_end = 1'b0;
         end else begin
            encode_plain(c, last);
         end
      end else begin
         encode_plain(c, last);
      end
      if (last) begin
         column_count = '0;
         space_at_end = 1'b0;
         cr_waiting = 1'b0;
      end
      for (int k = 0; k < run_count; k++) begin
         w.data = run_words[k];
         w.last = (k == run_count - 1);
         expected_words.push_back(w);
      end
   endtask

   // Watch both channels; results are compared before the new byte is queued.
   always @(posedge clock) begin
      if (reset) begin
         limit_copy = qpe_pkg::LIMIT_RESET;
         column_count = '0;
         space_at_end = 1'b0;
         cr_waiting = 1'b0;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            limit_copy = csr_write_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual %s",
                        $time, $sformatf("out_byte 8'h%02h run_last %0b",
                                         rsp_out_byte, rsp_run_last));
               error_total++;
            end else begin
               due = expected_words.pop_front();
               checked_total++;
               if (rsp_out_byte !== due.data) begin
                  $display("%0t: out_byte mismatch: expected 8'h%02h, actual 8'h%02h",
                           $time, due.data, rsp_out_byte);
                  error_total++;
               end
               if (rsp_run_last !== due.last) begin
                  $display("%0t: run_last mismatch: expected %0b, actual %0b",
                           $time, due.last, rsp_run_last);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_byte(req_in_byte, req_msg_last);
         end
      end
      fail_count <= error_total;
      words_pending <= expected_words.size();
      words_checked <= checked_total;
   end

endmodule

// File: bench/quoted_printable_encoder_tb.sv
`timescale 1ns / 100ps

module quoted_printable_encoder_tb;

   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES = 5;
   localparam int PHASE_COUNT = 7;
   localparam int LONG_ESCAPES = 85;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic [7:0] req_in_byte = '0;
   logic       req_msg_last = 1'b0;
   logic       rsp_ready = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire  [7:0] rsp_out_byte;
   wire        rsp_run_last;

   int fail_count;
   int words_pending;
   int words_checked;

   logic send_gaps = 1'b0;
   logic rsp_stalls = 1'b0;
   int   stall_left = 0;
   int   idle_cycles = 0;
   int   bytes_sent = 0;
   int   limits_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quoted_printable_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_msg_last     (req_msg_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last)
   );

   qpe_checker word_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_msg_last     (req_msg_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .fail_count       (fail_count),
      .words_pending    (words_pending),
      .words_checked    (words_checked)
   );

   // Receiver: random stall bursts while enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
         stall_left <= int'($urandom_range(0, 6));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: too long without a CSR write or any word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte, possibly after a gap, and wait until it is taken.
   task automatic send_byte(input logic [7:0] data, input logic last);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= data;
      req_msg_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stop sending and let every owed word come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [7:0] limit);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limits_used++;
   endtask

   // A message of mostly text, with hard breaks, whitespace and escapes mixed in.
   task automatic send_message(input int length);
      int         sent;
      int         pick;
      logic [7:0] data;
      sent = 0;
      while (sent < length) begin
         pick = $urandom_range(0, 99);
         if (pick < 10 && sent + 2 <= length) begin
            send_byte(qpe_pkg::CHAR_CR, 1'b0);
            send_byte(qpe_pkg::CHAR_LF, sent + 2 == length);
            sent += 2;
         end else begin
            if (pick < 50) begin
               data = 8'($urandom_range(qpe_pkg::PRINT_LOW, qpe_pkg::PRINT_HIGH));
            end else if (pick < 62) begin
               data = $urandom_range(0, 1) ? qpe_pkg::CHAR_SPACE : qpe_pkg::CHAR_TAB;
            end else if (pick < 67) begin
               data = qpe_pkg::CHAR_EQUALS;
            end else if (pick < 72) begin
               data = qpe_pkg::CHAR_CR;
            end else if (pick < 75) begin
               data = qpe_pkg::CHAR_LF;
            end else begin
               data = 8'($urandom_range(0, 255));
            end
            send_byte(data, sent + 1 == length);
            sent++;
         end
      end
   endtask

   // Escapes that fill the line up to the largest column, then a space that
   // must leave the column pinned there, so the next text byte breaks.
   task automatic send_long_line();
      for (int k = 0; k < LONG_ESCAPES; k++) begin
         send_byte(8'hc3, 1'b0);
      end
      send_byte(qpe_pkg::CHAR_SPACE, 1'b0);
      send_byte("Q", 1'b0);
      send_byte(8'hc3, 1'b1);
   endtask

   initial begin
      int         start;
      logic [7:0] limit;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes under the limit left by reset.
      send_byte("A", 1'b0);
      send_byte(qpe_pkg::CHAR_EQUALS, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(qpe_pkg::PRINT_LOW, 1'b0);
      send_byte(qpe_pkg::PRINT_HIGH, 1'b0);
      send_byte(8'h7f, 1'b0);
      // Whitespace before a hard break forces a soft break first.
      send_byte(qpe_pkg::CHAR_SPACE, 1'b0);
      send_byte(qpe_pkg::CHAR_TAB, 1'b0);
      send_byte(qpe_pkg::CHAR_CR, 1'b0);
      send_byte(qpe_pkg::CHAR_LF, 1'b0);
      // A bare LF is escaped; a CR not followed by LF is dropped.
      send_byte(qpe_pkg::CHAR_LF, 1'b0);
      send_byte(qpe_pkg::CHAR_CR, 1'b0);
      send_byte("x", 1'b0);
      send_byte(qpe_pkg::CHAR_CR, 1'b0);
      send_byte(qpe_pkg::CHAR_CR, 1'b0);
      send_byte(qpe_pkg::CHAR_LF, 1'b0);
      send_byte(qpe_pkg::CHAR_SPACE, 1'b1);

      // The smallest legal limit: soft breaks before text and escapes.
      set_limit(8'd4);
      send_byte("A", 1'b0);
      send_byte("B", 1'b0);
      send_byte("C", 1'b0);
      send_byte("D", 1'b0);
      send_byte("E", 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(qpe_pkg::CHAR_TAB, 1'b1);
      send_byte(qpe_pkg::CHAR_CR, 1'b1);
      send_byte("z", 1'b1);

      // Random messages under a series of limits; the last phase runs flat out.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         unique case (phase)
            0: limit = 8'd200;
            1: limit = 8'd0;
            2: limit = 8'd1;
            3: limit = 8'd255;
            4: limit = 8'($urandom_range(4, 200));
            5: limit = 8'd5;
            default: limit = qpe_pkg::LIMIT_RESET;
         endcase
         set_limit(limit);
         send_gaps = (phase < PHASE_COUNT - 1) && (phase != 2);
         rsp_stalls <= (phase < PHASE_COUNT - 1) && (phase != 4);
         if (phase == 3) begin
            send_long_line();
         end
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            send_message($urandom_range(1, 8));
            if (phase == 3 && bytes_sent - start >= PHASE_BYTES / 2 && words_pending != 0) begin
               drain();
            end
         end
      end

      drain();
      $display("Sent %0d message bytes and checked %0d encoded words under %0d line limits,",
               bytes_sent, words_checked, limits_used);
      $display("covering escapes, soft and hard breaks, dropped CRs, trailing whitespace");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
